/* src/imhk_pkg.sv */
// Shared types and constants for the indexed min-heap key update block.
`timescale 1ns / 1ps
package imhk_pkg;

   localparam int AGENTS_DEFAULT    = 256;
   localparam int TIME_BITS_DEFAULT = 32;

   localparam int AGENT_ID_W = 8;
   localparam int NEW_TIME_W = 32;
   localparam int SLOT_W     = 8;
   localparam int TOP_TIME_W = 32;
   localparam int COUNT_W    = 9;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

   // heap write actions
   typedef enum logic [2:0] {
      WR_NONE,
      WR_CLEAR,
      WR_MOVE_SEL,
      WR_MOVE_LEFT,
      WR_MOVE_PARENT,
      WR_PLACE
   } wr_kind_type;

   // heap read address forms, taken from the base position or the slot table read
   typedef enum logic [2:0] {
      RD_NONE,
      RD_SLOT,
      RD_CHILD,
      RD_LEFT,
      RD_PARENT
   } rd_kind_type;

   // which position the next step starts from
   typedef enum logic [1:0] {
      BASE_POS,
      BASE_SEL,
      BASE_LEFT,
      BASE_PARENT
   } base_type;

   typedef struct packed {
      wr_kind_type wr;
      rd_kind_type rd;
      base_type    base;
      logic        adv;
      logic        load_req;
      logic        load_slot;
      logic        set_moved;
      logic        load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic slot_ok;
      logic changed;
      logic pos_down_more;
      logic pos_down_last;
      logic pos_at_root;
      logic sel_down_more;
      logic sel_down_last;
      logic parent_later;
      logic par_at_root;
   } status_type;

endpackage

/* src/imhk_if.sv */
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface imhk_req_if import imhk_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [AGENT_ID_W-1:0] agent_id;
   logic [NEW_TIME_W-1:0] new_time;

   modport source (output valid, agent_id, new_time, input ready);
   modport sink   (input valid, agent_id, new_time, output ready);
endinterface

interface imhk_rsp_if import imhk_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [SLOT_W-1:0]     agent_slot;
   logic [AGENT_ID_W-1:0] top_agent;
   logic [TOP_TIME_W-1:0] top_time;
   logic                  moved;

   modport source (output valid, agent_slot, top_agent, top_time, moved, input ready);
   modport sink   (input valid, agent_slot, top_agent, top_time, moved, output ready);
endinterface

/* src/imhk_dpath.sv */
// Heap datapath: heap and position memories, position arithmetic, output register.
`timescale 1ns / 1ps
module imhk_dpath import imhk_pkg::*; #(
   parameter int AGENTS    = AGENTS_DEFAULT,
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [AGENT_ID_W-1:0] req_agent_id,
   input  logic [NEW_TIME_W-1:0] req_new_time,
   input  logic                  csr_we,
   input  logic [COUNT_W-1:0]    csr_wdata,
   output logic [SLOT_W-1:0]     rsp_agent_slot,
   output logic [AGENT_ID_W-1:0] rsp_top_agent,
   output logic [TOP_TIME_W-1:0] rsp_top_time,
   output logic                  rsp_moved
);

   localparam int AW = $clog2(AGENTS);
   localparam int SW = (AW > COUNT_W ? AW : COUNT_W) + 2;
   localparam logic [TIME_BITS-1:0] KEY_NONE = {TIME_BITS{1'b1}};
   localparam logic [AW-1:0] LAST_ENTRY = AW'(AGENTS - 1);

   // slot-indexed heap (agent and key side by side) and agent-indexed slot table
   logic [AW-1:0]        heap_agent_mem [AGENTS];
   logic [TIME_BITS-1:0] heap_key_mem   [AGENTS];
   logic [AW-1:0]        slot_mem       [AGENTS];

   logic [AW-1:0]        rd_a_agent_ff, rd_b_agent_ff, slot_rd_ff;
   logic [TIME_BITS-1:0] rd_a_key_ff, rd_b_key_ff;

   logic [AW-1:0]        agent_ff, pos_ff, clr_ff, top_agent_ff;
   logic [TIME_BITS-1:0] key_ff, top_key_ff;
   logic                 in_range_ff, moved_ff;
   logic [COUNT_W-1:0]   count_ff;

   logic [SLOT_W-1:0]     rsp_slot_ff;
   logic [AGENT_ID_W-1:0] rsp_top_agent_ff;
   logic [TOP_TIME_W-1:0] rsp_top_time_ff;
   logic                  rsp_moved_ff;

   logic [COUNT_W-1:0]   n;
   logic [SW-1:0]        n_w, half_w, last_w, pos_w, right_w, left_w, sel_w, par_w, base_w;
   logic                 n_even, sel_left;
   logic [SW-1:0]        ra_w, rb_w;
   logic [AW-1:0]        ra, rb;

   logic                 heap_we;
   logic [AW-1:0]        heap_wa, wagent;
   logic [TIME_BITS-1:0] wkey;
   logic [AW-1:0]        slot_wd;

   // effective count saturates at the heap depth
   assign n      = (32'(count_ff) > AGENTS) ? COUNT_W'(AGENTS) : count_ff;
   assign n_w    = SW'(n);
   assign half_w = (n_w - SW'(1)) >> 1;
   assign last_w = (n_w - SW'(2)) >> 1;
   assign n_even = ~n[0];

   assign pos_w    = SW'(pos_ff);
   assign right_w  = (pos_w << 1) + SW'(2);
   assign left_w   = right_w - SW'(1);
   assign sel_left = rd_a_key_ff > rd_b_key_ff;   // right wins ties
   assign sel_w    = sel_left ? left_w : right_w;
   assign par_w    = (pos_w - SW'(1)) >> 1;

   always_comb begin
      status.clr_last      = (clr_ff == LAST_ENTRY);
      status.slot_ok       = in_range_ff && (pos_w < n_w);
      status.changed       = (rd_a_key_ff != key_ff);
      status.pos_down_more = (pos_w < half_w);
      status.pos_down_last = n_even && (pos_w == last_w);
      status.pos_at_root   = (pos_w == '0);
      status.sel_down_more = (sel_w < half_w);
      status.sel_down_last = n_even && (sel_w == last_w);
      status.parent_later  = (rd_a_key_ff > key_ff);
      status.par_at_root   = (par_w == '0);
   end

   always_comb begin
      case (cmd.base)
         BASE_POS:    base_w = pos_w;
         BASE_SEL:    base_w = sel_w;
         BASE_LEFT:   base_w = left_w;
         BASE_PARENT: base_w = par_w;
         default:     base_w = pos_w;
      endcase
   end

   always_comb begin
      ra_w = '0;
      rb_w = '0;
      case (cmd.rd)
         RD_SLOT:   ra_w = SW'(slot_rd_ff);
         RD_CHILD: begin
            ra_w = (base_w << 1) + SW'(2);
            rb_w = (base_w << 1) + SW'(1);
         end
         RD_LEFT:   rb_w = (base_w << 1) + SW'(1);
         RD_PARENT: ra_w = (base_w - SW'(1)) >> 1;
         default: begin
            ra_w = '0;
            rb_w = '0;
         end
      endcase
   end

   assign ra = ra_w[AW-1:0];
   assign rb = rb_w[AW-1:0];

   always_comb begin
      heap_we = 1'b1;
      heap_wa = pos_ff;
      wagent  = agent_ff;
      wkey    = key_ff;
      slot_wd = pos_ff;
      case (cmd.wr)
         WR_CLEAR: begin
            heap_wa = clr_ff;
            wagent  = clr_ff;
            wkey    = KEY_NONE;
            slot_wd = clr_ff;
         end
         WR_MOVE_SEL: begin
            wagent = sel_left ? rd_b_agent_ff : rd_a_agent_ff;
            wkey   = sel_left ? rd_b_key_ff : rd_a_key_ff;
         end
         WR_MOVE_LEFT: begin
            wagent = rd_b_agent_ff;
            wkey   = rd_b_key_ff;
         end
         WR_MOVE_PARENT: begin
            wagent = rd_a_agent_ff;
            wkey   = rd_a_key_ff;
         end
         WR_PLACE: begin
            wagent = agent_ff;
            wkey   = key_ff;
         end
         default: heap_we = 1'b0;
      endcase
   end

   // heap memory: one write, two reads, write data forwarded on a same-slot read
   always_ff @(posedge clock) begin
      if (heap_we) begin
         heap_agent_mem[heap_wa] <= wagent;
         heap_key_mem[heap_wa]   <= wkey;
      end
      if (heap_we && heap_wa == ra) begin
         rd_a_agent_ff <= wagent;
         rd_a_key_ff   <= wkey;
      end else begin
         rd_a_agent_ff <= heap_agent_mem[ra];
         rd_a_key_ff   <= heap_key_mem[ra];
      end
      if (heap_we && heap_wa == rb) begin
         rd_b_agent_ff <= wagent;
         rd_b_key_ff   <= wkey;
      end else begin
         rd_b_agent_ff <= heap_agent_mem[rb];
         rd_b_key_ff   <= heap_key_mem[rb];
      end
   end

   // slot-of-agent table follows every heap write
   always_ff @(posedge clock) begin
      if (heap_we) begin
         slot_mem[wagent] <= slot_wd;
      end
      slot_rd_ff <= slot_mem[AW'(req_agent_id)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff   <= '0;
         count_ff <= COUNT_RESET;
      end else begin
         if (cmd.wr == WR_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (heap_we && heap_wa == '0) begin
         top_agent_ff <= wagent;
         top_key_ff   <= wkey;
      end
      if (cmd.load_req) begin
         agent_ff    <= AW'(req_agent_id);
         key_ff      <= TIME_BITS'(req_new_time);
         in_range_ff <= (32'(req_agent_id) < AGENTS);
         moved_ff    <= 1'b0;
      end else if (cmd.set_moved) begin
         moved_ff <= 1'b1;
      end
      if (cmd.load_slot) begin
         pos_ff <= slot_rd_ff;
      end else if (cmd.adv) begin
         pos_ff <= AW'(base_w);
      end
      if (cmd.load_rsp) begin
         rsp_slot_ff      <= in_range_ff ? SLOT_W'(pos_ff) : '0;
         rsp_top_agent_ff <= AGENT_ID_W'(top_agent_ff);
         rsp_top_time_ff  <= TOP_TIME_W'(top_key_ff);
         rsp_moved_ff     <= moved_ff;
      end
   end

   assign rsp_agent_slot = rsp_slot_ff;
   assign rsp_top_agent  = rsp_top_agent_ff;
   assign rsp_top_time   = rsp_top_time_ff;
   assign rsp_moved      = rsp_moved_ff;

endmodule

/* src/imhk_ctrl.sv */
// Sequencer for the heap update: clearing pass, lookup, sift down, sift up, result.
`timescale 1ns / 1ps
module imhk_ctrl import imhk_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      CLEAR,
      IDLE,
      LOOKUP,
      CHECK,
      DOWN,
      LAST,
      UP,
      PLACE,
      DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '{wr: WR_NONE, rd: RD_NONE, base: BASE_POS, default: 1'b0};
      case (state_ff)
         CLEAR: begin
            cmd.wr = WR_CLEAR;
            if (status.clr_last) begin
               state_in = IDLE;
            end
         end
         IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = LOOKUP;
            end
         end
         LOOKUP: begin
            cmd.load_slot = 1'b1;
            cmd.rd        = RD_SLOT;
            state_in      = CHECK;
         end
         CHECK: begin
            if (status.slot_ok && status.changed) begin
               cmd.set_moved = 1'b1;
               cmd.base      = BASE_POS;
               if (status.pos_down_more) begin
                  cmd.rd   = RD_CHILD;
                  state_in = DOWN;
               end else if (status.pos_down_last) begin
                  cmd.rd   = RD_LEFT;
                  state_in = LAST;
               end else if (!status.pos_at_root) begin
                  cmd.rd   = RD_PARENT;
                  state_in = UP;
               end else begin
                  state_in = PLACE;
               end
            end else begin
               state_in = DONE;
            end
         end
         DOWN: begin
            cmd.wr   = WR_MOVE_SEL;
            cmd.adv  = 1'b1;
            cmd.base = BASE_SEL;
            if (status.sel_down_more) begin
               cmd.rd   = RD_CHILD;
               state_in = DOWN;
            end else if (status.sel_down_last) begin
               cmd.rd   = RD_LEFT;
               state_in = LAST;
            end else begin
               cmd.rd   = RD_PARENT;
               state_in = UP;
            end
         end
         LAST: begin
            cmd.wr   = WR_MOVE_LEFT;
            cmd.adv  = 1'b1;
            cmd.base = BASE_LEFT;
            cmd.rd   = RD_PARENT;
            state_in = UP;
         end
         UP: begin
            if (status.parent_later) begin
               cmd.wr   = WR_MOVE_PARENT;
               cmd.adv  = 1'b1;
               cmd.base = BASE_PARENT;
               if (status.par_at_root) begin
                  state_in = PLACE;
               end else begin
                  cmd.rd   = RD_PARENT;
                  state_in = UP;
               end
            end else begin
               state_in = PLACE;
            end
         end
         PLACE: begin
            cmd.wr   = WR_PLACE;
            state_in = DONE;
         end
         DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* src/indexed_min_heap_key_update.sv */
// Top level of the indexed min-heap key update block.
`timescale 1ns / 1ps
// Keeps agents in a binary min-heap on their next event times, with a table
// giving each agent's heap slot. Each request beat names an agent and its new
// time; one response beat returns the agent's slot after the fix-up, the root
// agent and its time, and whether the heap was touched. After reset the block
// sweeps its memories (slot i holds agent i, every time all
// ones) and takes no request beat until that is done; csr writes are taken at
// any time. An item where nothing moves goes from the lookup straight to
// the result; otherwise the agent walks down the heap and then up it, one
// heap level per cycle on the two-read heap memory, before its key is placed.
// A finished response waits in an output register while the next request is
// accepted.
module indexed_min_heap_key_update import imhk_pkg::*; #(
   parameter int AGENTS    = AGENTS_DEFAULT,
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   imhk_req_if.sink           req_bus,
   imhk_rsp_if.source         rsp_bus,
   input  logic               csr_we,
   input  logic [COUNT_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   imhk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   imhk_dpath #(
      .AGENTS    (AGENTS),
      .TIME_BITS (TIME_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_agent_id   (req_bus.agent_id),
      .req_new_time   (req_bus.new_time),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .rsp_agent_slot (rsp_bus.agent_slot),
      .rsp_top_agent  (rsp_bus.top_agent),
      .rsp_top_time   (rsp_bus.top_time),
      .rsp_moved      (rsp_bus.moved)
   );

endmodule
